// ===== hw/rtl/mtep_pkg.sv =====
`default_nettype none

package mtep_pkg;

  // Record kinds on the result channel.
  localparam logic [2:0] KIND_CHAN  = 3'd0;
  localparam logic [2:0] KIND_META  = 3'd1;
  localparam logic [2:0] KIND_SYSEX = 3'd2;
  localparam logic [2:0] KIND_PAY   = 3'd3;
  localparam logic [2:0] KIND_EMPTY = 3'd4;

  // Status and meta codes of the track format.
  localparam logic [7:0] ST_META       = 8'hFF;
  localparam logic [7:0] ST_SYSEX      = 8'hF0;
  localparam logic [7:0] ST_SYSEX_ESC  = 8'hF7;
  localparam logic [3:0] HI_PROG       = 4'hC;
  localparam logic [3:0] HI_CHAN_PRESS = 4'hD;
  localparam logic [7:0] META_TEMPO    = 8'h51;
  localparam logic [7:0] META_END      = 8'h2F;

  // One result record, field for field.
  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] tick;
    logic [7:0]  status;
    logic [7:0]  d1;
    logic [7:0]  d2;
    logic [1:0]  cnt;
    logic [7:0]  meta;
    logic [31:0] blen;
    logic [7:0]  pay;
    logic        tf;
    logic [23:0] tempo;
    logic        fin;
  } rec_t;

  // One queue entry: an optional payload byte record followed by an optional
  // main record. Both share tick, status, meta kind and length; the main
  // record shows its length only when it finishes the track.
  typedef struct packed {
    logic pay_vld;
    logic main_vld;
    rec_t rec;
  } entry_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mtep_front.sv =====
`default_nettype none

module mtep_front (
  input  wire                logic clk,
  input  wire                logic rst_n,
  input  wire                logic in_valid,
  input  wire                logic [7:0] in_byte,
  output logic               in_ready,
  input  wire                logic q_full,
  output logic               q_push,
  output mtep_pkg::entry_t   q_data
);

  typedef enum logic [3:0] {
    PH_HEADER,
    PH_DELTA,
    PH_STATUS,
    PH_DATA1,
    PH_DATA2,
    PH_MTYPE,
    PH_LENGTH,
    PH_PAYLOAD,
    PH_DONE
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [2:0]  hp_r, hp_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] cons_r, cons_nxt;
  logic [31:0] tick_r, tick_nxt;
  logic [31:0] vlq_r, vlq_nxt;
  logic [7:0]  rs_r, rs_nxt;
  logic [7:0]  cs_r, cs_nxt;
  logic [7:0]  held_r, held_nxt;
  logic [7:0]  meta_r, meta_nxt;
  logic [31:0] left_r, left_nxt;
  logic [23:0] tempo_r, tempo_nxt;

  logic acc;

  // The queue absorbs every record, so input flow only depends on its room.
  assign in_ready = ~q_full;
  assign acc      = in_valid & in_ready;

  // Byte classification and record assembly.
  always_comb begin
    logic [31:0] cons_inc;
    logic [31:0] vlq_shift;
    logic [7:0]  cs_sel;
    logic [31:0] raw_len;
    logic [23:0] tempo_v;
    logic        do_first;
    logic        do_body;
    logic        do_end;
    logic        end_meta;
    logic        fin;

    cons_inc  = cons_r + 32'd1;
    vlq_shift = {vlq_r[24:0], in_byte[6:0]};
    cs_sel    = cs_r;
    raw_len   = '0;
    tempo_v   = '0;
    do_first  = 1'b0;
    do_body   = 1'b0;
    do_end    = 1'b0;
    end_meta  = 1'b0;
    fin       = 1'b0;

    phase_nxt = phase_r;
    hp_nxt    = hp_r;
    len_nxt   = len_r;
    cons_nxt  = cons_r;
    tick_nxt  = tick_r;
    vlq_nxt   = vlq_r;
    rs_nxt    = rs_r;
    cs_nxt    = cs_r;
    held_nxt  = held_r;
    meta_nxt  = meta_r;
    left_nxt  = left_r;
    tempo_nxt = tempo_r;

    q_push          = 1'b0;
    q_data          = '0;
    q_data.rec.tick = tick_r;

    if (acc) begin
      case (phase_r)
        PH_HEADER: begin
          if (hp_r >= 3'd4) begin
            len_nxt = {len_r[23:0], in_byte};
          end
          if (hp_r != 3'd7) begin
            hp_nxt = hp_r + 3'd1;
          end else begin
            hp_nxt   = '0;
            cons_nxt = '0;
            tick_nxt = '0;
            vlq_nxt  = '0;
            if (len_nxt == 32'd0) begin
              phase_nxt           = PH_DONE;
              q_push              = 1'b1;
              q_data.main_vld     = 1'b1;
              q_data.rec.kind     = mtep_pkg::KIND_EMPTY;
              q_data.rec.tick     = '0;
              q_data.rec.fin      = 1'b1;
            end else begin
              phase_nxt = PH_DELTA;
            end
          end
        end
        PH_DELTA: begin
          cons_nxt = cons_inc;
          vlq_nxt  = vlq_shift;
          if (!in_byte[7]) begin
            tick_nxt  = tick_r + vlq_shift;
            phase_nxt = PH_STATUS;
          end
        end
        PH_STATUS: begin
          cons_nxt = cons_inc;
          if (in_byte == mtep_pkg::ST_META) begin
            cs_nxt    = mtep_pkg::ST_META;
            phase_nxt = PH_MTYPE;
          end else if (in_byte == mtep_pkg::ST_SYSEX || in_byte == mtep_pkg::ST_SYSEX_ESC) begin
            cs_nxt    = in_byte;
            vlq_nxt   = '0;
            phase_nxt = PH_LENGTH;
          end else if (in_byte[7]) begin
            rs_nxt    = in_byte;
            cs_nxt    = in_byte;
            phase_nxt = PH_DATA1;
          end else begin
            // Running status: a data byte reuses the last channel status.
            cs_nxt   = rs_r;
            cs_sel   = rs_r;
            do_first = 1'b1;
          end
        end
        PH_DATA1: begin
          cons_nxt = cons_inc;
          do_first = 1'b1;
        end
        PH_DATA2: begin
          cons_nxt          = cons_inc;
          do_end            = 1'b1;
          q_push            = 1'b1;
          q_data.main_vld   = 1'b1;
          q_data.rec.kind   = mtep_pkg::KIND_CHAN;
          q_data.rec.status = cs_r;
          q_data.rec.d1     = held_r;
          q_data.rec.d2     = in_byte;
          q_data.rec.cnt    = 2'd2;
        end
        PH_MTYPE: begin
          cons_nxt  = cons_inc;
          meta_nxt  = in_byte;
          vlq_nxt   = '0;
          phase_nxt = PH_LENGTH;
        end
        PH_LENGTH: begin
          cons_nxt = cons_inc;
          vlq_nxt  = vlq_shift;
          if (!in_byte[7]) begin
            left_nxt  = vlq_shift;
            tempo_nxt = '0;
            if (vlq_shift == 32'd0) begin
              do_body = 1'b1;
              raw_len = vlq_shift;
            end else begin
              phase_nxt = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          cons_nxt          = cons_inc;
          tempo_nxt         = {tempo_r[15:0], in_byte};
          left_nxt          = left_r - 32'd1;
          q_push            = 1'b1;
          q_data.pay_vld    = 1'b1;
          q_data.rec.pay    = in_byte;
          q_data.rec.status = cs_r;
          q_data.rec.meta   = (cs_r == mtep_pkg::ST_META) ? meta_r : 8'd0;
          q_data.rec.blen   = vlq_r;
          if (left_nxt == 32'd0) begin
            do_body = 1'b1;
            raw_len = vlq_r;
            tempo_v = tempo_nxt;
          end
        end
        default: begin
        end
      endcase
    end

    // First channel data byte: one-byte events finish here.
    if (do_first) begin
      if (cs_sel[7:4] == mtep_pkg::HI_PROG || cs_sel[7:4] == mtep_pkg::HI_CHAN_PRESS) begin
        do_end            = 1'b1;
        q_push            = 1'b1;
        q_data.main_vld   = 1'b1;
        q_data.rec.kind   = mtep_pkg::KIND_CHAN;
        q_data.rec.status = cs_sel;
        q_data.rec.d1     = in_byte;
        q_data.rec.cnt    = 2'd1;
      end else begin
        held_nxt  = in_byte;
        phase_nxt = PH_DATA2;
      end
    end

    // Meta or sysex record after the last payload byte, or after a zero length.
    if (do_body) begin
      do_end          = 1'b1;
      q_push          = 1'b1;
      q_data.main_vld = 1'b1;
      q_data.rec.blen = raw_len;
      if (cs_r == mtep_pkg::ST_META) begin
        end_meta          = (meta_r == mtep_pkg::META_END);
        q_data.rec.kind   = mtep_pkg::KIND_META;
        q_data.rec.status = mtep_pkg::ST_META;
        q_data.rec.meta   = meta_r;
        q_data.rec.tf     = (meta_r == mtep_pkg::META_TEMPO) && (raw_len == 32'd3);
        q_data.rec.tempo  = q_data.rec.tf ? tempo_v : 24'd0;
      end else begin
        q_data.rec.kind   = mtep_pkg::KIND_SYSEX;
        q_data.rec.status = cs_r;
        q_data.rec.meta   = 8'd0;
      end
    end

    // Event boundary: end of the track, or back to the next delta time.
    if (do_end) begin
      fin            = end_meta || (cons_nxt >= len_r);
      q_data.rec.fin = fin;
      if (fin) begin
        phase_nxt = PH_DONE;
      end else begin
        phase_nxt = PH_DELTA;
        vlq_nxt   = '0;
      end
    end
  end

  // Parser state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      hp_r    <= '0;
      len_r   <= '0;
      cons_r  <= '0;
      tick_r  <= '0;
      vlq_r   <= '0;
      rs_r    <= '0;
      cs_r    <= '0;
      held_r  <= '0;
      meta_r  <= '0;
      left_r  <= '0;
      tempo_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      hp_r    <= hp_nxt;
      len_r   <= len_nxt;
      cons_r  <= cons_nxt;
      tick_r  <= tick_nxt;
      vlq_r   <= vlq_nxt;
      rs_r    <= rs_nxt;
      cs_r    <= cs_nxt;
      held_r  <= held_nxt;
      meta_r  <= meta_nxt;
      left_r  <= left_nxt;
      tempo_r <= tempo_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mtep_fifo.sv =====
`default_nettype none

module mtep_fifo #(
  parameter int DEPTH = 4
) (
  input  wire              logic clk,
  input  wire              logic rst_n,
  input  wire              logic push,
  input  wire mtep_pkg::entry_t push_data,
  output logic             full,
  input  wire              logic pop,
  output mtep_pkg::entry_t pop_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  mtep_pkg::entry_t mem_r [DEPTH];
  logic [AW-1:0] wp_r, wp_nxt;
  logic [AW-1:0] rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == CW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rp_r];

  // Pointer and fill count update.
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + AW'(1);
    end
    if (pop) begin
      rp_nxt = (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + AW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full || pop)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("queue read while empty");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/mtep_back.sv =====
`default_nettype none

module mtep_back (
  input  wire              logic clk,
  input  wire              logic rst_n,
  input  wire mtep_pkg::entry_t head,
  input  wire              logic empty,
  output logic             pop,
  input  wire              logic out_ready,
  output logic             out_valid,
  output mtep_pkg::rec_t   out_rec
);

  logic           vld_r, vld_nxt;
  logic           sent_r, sent_nxt;
  mtep_pkg::rec_t rec_r, rec_nxt;

  assign out_valid = vld_r;
  assign out_rec   = rec_r;

  // Expand one queue entry into its payload record and its main record.
  always_comb begin
    logic load;

    load     = !vld_r || out_ready;
    pop      = 1'b0;
    sent_nxt = sent_r;
    vld_nxt  = vld_r && !out_ready;
    rec_nxt  = rec_r;
    if (load && !empty) begin
      vld_nxt = 1'b1;
      if (head.pay_vld && !sent_r) begin
        rec_nxt        = '0;
        rec_nxt.kind   = mtep_pkg::KIND_PAY;
        rec_nxt.tick   = head.rec.tick;
        rec_nxt.status = head.rec.status;
        rec_nxt.meta   = head.rec.meta;
        rec_nxt.blen   = head.rec.blen;
        rec_nxt.pay    = head.rec.pay;
        if (head.main_vld) begin
          sent_nxt = 1'b1;
        end else begin
          pop = 1'b1;
        end
      end else begin
        rec_nxt      = head.rec;
        rec_nxt.pay  = 8'd0;
        // The event length shows only on the record that ends the track.
        rec_nxt.blen = head.rec.fin ? head.rec.blen : 32'd0;
        pop          = 1'b1;
        sent_nxt     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      sent_r <= 1'b0;
    end else begin
      vld_r  <= vld_nxt;
      sent_r <= sent_nxt;
    end
    rec_r <= rec_nxt;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/midi_track_event_parser.sv =====
// MIDI track chunk parser.
// Input channel: in_valid/in_ready with in_byte, one raw byte of the track
// chunk per transaction: four name bytes, a big-endian 32-bit body length,
// then delta-time and event pairs.
// Result channel: out_valid/out_ready with one record per transaction: a
// channel, meta or sysex event, a meta or sysex payload byte, or an empty
// track marker. A payload's last byte yields two records, the byte first.
// Throughput: one byte per cycle in while the queue has room; one record
// per cycle out while out_ready is high. The front parser classifies a
// byte in the cycle it is accepted and writes a queue entry; the back end
// reads the queue and drives the output register. When the receiver
// stalls the queue fills; in_ready drops only when the queue is full, so
// FIFO_DEPTH bytes with results can be absorbed.
// Reset (rst_n low, synchronous) returns to the chunk header phase with all
// counters cleared and the queue and output register empty. Bytes after the
// end of the track are taken and ignored until the next reset.
`default_nettype none

module midi_track_event_parser #(
  parameter int FIFO_DEPTH = 4
) (
  input  wire  logic        clk,
  input  wire  logic        rst_n,
  input  wire  logic        in_valid,
  output logic              in_ready,
  input  wire  logic [7:0]  in_byte,
  output logic              out_valid,
  input  wire  logic        out_ready,
  output logic [2:0]        out_record_kind,
  output logic [31:0]       out_event_tick,
  output logic [7:0]        out_status_value,
  output logic [7:0]        out_first_data,
  output logic [7:0]        out_second_data,
  output logic [1:0]        out_data_count,
  output logic [7:0]        out_meta_kind,
  output logic [31:0]       out_body_length,
  output logic [7:0]        out_payload_value,
  output logic              out_tempo_found,
  output logic [23:0]       out_tempo_micros,
  output logic              out_track_finished
);

  logic             q_full;
  logic             q_empty;
  logic             q_push;
  logic             q_pop;
  mtep_pkg::entry_t q_wdata;
  mtep_pkg::entry_t q_rdata;
  mtep_pkg::rec_t   rec;

  // Byte parser.
  mtep_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_byte  (in_byte),
    .in_ready (in_ready),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wdata)
  );

  // Record queue between parser and output.
  mtep_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  // Output register and record expansion.
  mtep_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_rdata),
    .empty     (q_empty),
    .pop       (q_pop),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_rec   (rec)
  );

  assign out_record_kind    = rec.kind;
  assign out_event_tick     = rec.tick;
  assign out_status_value   = rec.status;
  assign out_first_data     = rec.d1;
  assign out_second_data    = rec.d2;
  assign out_data_count     = rec.cnt;
  assign out_meta_kind      = rec.meta;
  assign out_body_length    = rec.blen;
  assign out_payload_value  = rec.pay;
  assign out_tempo_found    = rec.tf;
  assign out_tempo_micros   = rec.tempo;
  assign out_track_finished = rec.fin;

`ifndef SYNTH
  a_pay_not_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_record_kind == mtep_pkg::KIND_PAY |-> !out_track_finished)
    else $error("payload record marked as track end");

  a_tempo_meta: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_tempo_found |->
      out_record_kind == mtep_pkg::KIND_META && out_meta_kind == mtep_pkg::META_TEMPO)
    else $error("tempo reported on a non-tempo record");

  a_chan_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_record_kind == mtep_pkg::KIND_CHAN |->
      out_data_count == 2'd1 || out_data_count == 2'd2)
    else $error("channel record with bad data count");
`endif

endmodule

`default_nettype wire

// ===== verif/midi_track_event_checker.sv =====
`timescale 1ns / 100ps

// Watches both channels of the track parser, predicts the records that each
// accepted byte causes and compares every accepted record with the oldest
// prediction, field by field.
module midi_track_event_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [7:0]  in_byte,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [2:0]  out_record_kind,
  input  wire logic [31:0] out_event_tick,
  input  wire logic [7:0]  out_status_value,
  input  wire logic [7:0]  out_first_data,
  input  wire logic [7:0]  out_second_data,
  input  wire logic [1:0]  out_data_count,
  input  wire logic [7:0]  out_meta_kind,
  input  wire logic [31:0] out_body_length,
  input  wire logic [7:0]  out_payload_value,
  input  wire logic        out_tempo_found,
  input  wire logic [23:0] out_tempo_micros,
  input  wire logic        out_track_finished,
  output int               mismatches,
  output int               pending
);

  typedef enum logic [3:0] {
    SCAN_HEADER,
    SCAN_DELTA,
    SCAN_STATUS,
    SCAN_DATA1,
    SCAN_DATA2,
    SCAN_META_TYPE,
    SCAN_LENGTH,
    SCAN_PAYLOAD,
    SCAN_DONE
  } scan_phase_t;

  // Shadow copy of the parser state.
  scan_phase_t phase;
  logic [2:0]  header_pos;
  logic [31:0] chunk_len;
  logic [31:0] consumed;
  logic [31:0] tick_sum;
  logic [31:0] vlq;
  logic [7:0]  running_st;
  logic [7:0]  cur_st;
  logic [7:0]  held_d1;
  logic [7:0]  held_meta;
  logic [31:0] payload_left;
  logic [23:0] tempo_bytes;

  mtep_pkg::rec_t expected_records[$];
  mtep_pkg::rec_t want;

  function automatic mtep_pkg::rec_t make_rec(input logic [2:0] kind, input logic [7:0] st,
                                              input logic [7:0] d1, input logic [7:0] d2,
                                              input logic [1:0] cnt, input logic [7:0] mk,
                                              input logic [31:0] blen, input logic [7:0] pv,
                                              input logic tf, input logic [23:0] tm,
                                              input logic fin);
    mtep_pkg::rec_t r;
    r.kind   = kind;
    r.tick   = tick_sum;
    r.status = st;
    r.d1     = d1;
    r.d2     = d2;
    r.cnt    = cnt;
    r.meta   = mk;
    r.blen   = blen;
    r.pay    = pv;
    r.tf     = tf;
    r.tempo  = tm;
    r.fin    = fin;
    return r;
  endfunction

  // Append one predicted record behind the older ones.
  task automatic queue_record(input mtep_pkg::rec_t r);
    expected_records.insert(expected_records.size(), r);
  endtask

  // At an event boundary the track ends on the end meta event or once the
  // consumed bytes reach the chunk length.
  task automatic finish_event(input logic end_meta, output logic fin);
    fin = end_meta || (consumed >= chunk_len);
    if (fin) begin
      phase = SCAN_DONE;
    end else begin
      phase = SCAN_DELTA;
      vlq   = '0;
    end
  endtask

  // Program change and channel pressure carry a single data byte.
  task automatic take_first_data(input logic [7:0] b);
    logic fin;
    if (cur_st[7:4] == mtep_pkg::HI_PROG || cur_st[7:4] == mtep_pkg::HI_CHAN_PRESS) begin
      finish_event(1'b0, fin);
      queue_record(make_rec(mtep_pkg::KIND_CHAN, cur_st, b, 8'h00, 2'd1, 8'h00,
                            32'h0, 8'h00, 1'b0, 24'h0, fin));
    end else begin
      held_d1 = b;
      phase   = SCAN_DATA2;
    end
  endtask

  // The meta or sysex record itself. The length is cleared by the boundary
  // unless the track ends, so it only shows on a finishing record.
  task automatic close_body();
    logic fin;
    logic tf;
    if (cur_st == mtep_pkg::ST_META) begin
      tf = (held_meta == mtep_pkg::META_TEMPO) && (vlq == 32'd3);
      finish_event(held_meta == mtep_pkg::META_END, fin);
      queue_record(make_rec(mtep_pkg::KIND_META, mtep_pkg::ST_META, 8'h00, 8'h00, 2'd0,
                            held_meta, vlq, 8'h00, tf,
                            tf ? tempo_bytes : 24'h0, fin));
    end else begin
      finish_event(1'b0, fin);
      queue_record(make_rec(mtep_pkg::KIND_SYSEX, cur_st, 8'h00, 8'h00, 2'd0, 8'h00,
                            vlq, 8'h00, 1'b0, 24'h0, fin));
    end
  endtask

  // Advance the shadow parser by one byte and queue the records it causes.
  task automatic parse_track_byte(input logic [7:0] b);
    logic fin;
    case (phase)
      SCAN_HEADER: begin
        if (header_pos >= 3'd4) chunk_len = {chunk_len[23:0], b};
        if (header_pos < 3'd7) begin
          header_pos = header_pos + 3'd1;
        end else begin
          header_pos = '0;
          consumed   = '0;
          tick_sum   = '0;
          vlq        = '0;
          if (chunk_len == 32'd0) begin
            phase = SCAN_DONE;
            queue_record(make_rec(mtep_pkg::KIND_EMPTY, 8'h00, 8'h00, 8'h00, 2'd0,
                                  8'h00, 32'h0, 8'h00, 1'b0, 24'h0, 1'b1));
          end else begin
            phase = SCAN_DELTA;
          end
        end
      end
      SCAN_DELTA: begin
        consumed = consumed + 32'd1;
        vlq      = {vlq[24:0], b[6:0]};
        if (!b[7]) begin
          tick_sum = tick_sum + vlq;
          phase    = SCAN_STATUS;
        end
      end
      SCAN_STATUS: begin
        consumed = consumed + 32'd1;
        if (b == mtep_pkg::ST_META) begin
          cur_st = mtep_pkg::ST_META;
          phase  = SCAN_META_TYPE;
        end else if (b == mtep_pkg::ST_SYSEX || b == mtep_pkg::ST_SYSEX_ESC) begin
          cur_st = b;
          vlq    = '0;
          phase  = SCAN_LENGTH;
        end else if (b[7]) begin
          running_st = b;
          cur_st     = b;
          phase      = SCAN_DATA1;
        end else begin
          // Running status: the byte is already the first data byte.
          cur_st = running_st;
          take_first_data(b);
        end
      end
      SCAN_DATA1: begin
        consumed = consumed + 32'd1;
        take_first_data(b);
      end
      SCAN_DATA2: begin
        consumed = consumed + 32'd1;
        finish_event(1'b0, fin);
        queue_record(make_rec(mtep_pkg::KIND_CHAN, cur_st, held_d1, b, 2'd2, 8'h00,
                              32'h0, 8'h00, 1'b0, 24'h0, fin));
      end
      SCAN_META_TYPE: begin
        consumed  = consumed + 32'd1;
        held_meta = b;
        vlq       = '0;
        phase     = SCAN_LENGTH;
      end
      SCAN_LENGTH: begin
        consumed = consumed + 32'd1;
        vlq      = {vlq[24:0], b[6:0]};
        if (!b[7]) begin
          payload_left = vlq;
          tempo_bytes  = '0;
          if (payload_left == 32'd0) close_body();
          else phase = SCAN_PAYLOAD;
        end
      end
      SCAN_PAYLOAD: begin
        consumed    = consumed + 32'd1;
        tempo_bytes = {tempo_bytes[15:0], b};
        queue_record(make_rec(mtep_pkg::KIND_PAY, cur_st, 8'h00, 8'h00, 2'd0,
                              (cur_st == mtep_pkg::ST_META) ? held_meta : 8'h00,
                              vlq, b, 1'b0, 24'h0, 1'b0));
        payload_left = payload_left - 32'd1;
        // The last payload byte is followed by the event record itself.
        if (payload_left == 32'd0) close_body();
      end
      default: begin
        // Bytes after the end of the track are ignored.
      end
    endcase
  endtask

  task automatic check_field(input string fname, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (want_v !== got_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, fname, want_v, got_v);
    end
  endtask

  // Compare each result transaction first, then predict from the input one.
  always @(posedge clk) begin
    if (!rst_n) begin
      phase        = SCAN_HEADER;
      header_pos   = '0;
      chunk_len    = '0;
      consumed     = '0;
      tick_sum     = '0;
      vlq          = '0;
      running_st   = '0;
      cur_st       = '0;
      held_d1      = '0;
      held_meta    = '0;
      payload_left = '0;
      tempo_bytes  = '0;
      expected_records.delete();
      mismatches   = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_records.size() == 0) begin
          mismatches++;
          $display("%0t: record transaction with none expected, actual kind %0d tick 0x%0h",
                   $time, out_record_kind, out_event_tick);
        end else begin
          want = expected_records.pop_front();
          check_field("record_kind", 32'(want.kind), 32'(out_record_kind));
          check_field("event_tick", want.tick, out_event_tick);
          check_field("status_value", 32'(want.status), 32'(out_status_value));
          check_field("first_data", 32'(want.d1), 32'(out_first_data));
          check_field("second_data", 32'(want.d2), 32'(out_second_data));
          check_field("data_count", 32'(want.cnt), 32'(out_data_count));
          check_field("meta_kind", 32'(want.meta), 32'(out_meta_kind));
          check_field("body_length", want.blen, out_body_length);
          check_field("payload_value", 32'(want.pay), 32'(out_payload_value));
          check_field("tempo_found", 32'(want.tf), 32'(out_tempo_found));
          check_field("tempo_micros", 32'(want.tempo), 32'(out_tempo_micros));
          check_field("track_finished", 32'(want.fin), 32'(out_track_finished));
        end
      end
      if (in_valid && in_ready) parse_track_byte(in_byte);
    end
    pending = expected_records.size();
  end

endmodule

// ===== verif/midi_track_event_parser_tb.sv =====
`timescale 1ns / 100ps

// Feeds one track chunk through the parser with random idling on both sides
// and leaves the checking to the checker beside the block.
module midi_track_event_parser_tb;

  localparam int BODY_TARGET = 820;
  localparam int TAIL_ITEMS  = 100;
  localparam int QUIET_LIMIT = 500;
  localparam int DRAIN_LIMIT = 20;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_byte;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_record_kind;
  logic [31:0] out_event_tick;
  logic [7:0]  out_status_value;
  logic [7:0]  out_first_data;
  logic [7:0]  out_second_data;
  logic [1:0]  out_data_count;
  logic [7:0]  out_meta_kind;
  logic [31:0] out_body_length;
  logic [7:0]  out_payload_value;
  logic        out_tempo_found;
  logic [23:0] out_tempo_micros;
  logic        out_track_finished;

  int          mismatch_total;
  int          records_pending;
  logic        tail_calm;

  logic [7:0]  body_bytes[$];
  logic [7:0]  feed_bytes[$];
  logic [7:0]  gen_running;

  midi_track_event_parser i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_byte            (in_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_record_kind    (out_record_kind),
    .out_event_tick     (out_event_tick),
    .out_status_value   (out_status_value),
    .out_first_data     (out_first_data),
    .out_second_data    (out_second_data),
    .out_data_count     (out_data_count),
    .out_meta_kind      (out_meta_kind),
    .out_body_length    (out_body_length),
    .out_payload_value  (out_payload_value),
    .out_tempo_found    (out_tempo_found),
    .out_tempo_micros   (out_tempo_micros),
    .out_track_finished (out_track_finished)
  );

  midi_track_event_checker u_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_byte            (in_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_record_kind    (out_record_kind),
    .out_event_tick     (out_event_tick),
    .out_status_value   (out_status_value),
    .out_first_data     (out_first_data),
    .out_second_data    (out_second_data),
    .out_data_count     (out_data_count),
    .out_meta_kind      (out_meta_kind),
    .out_body_length    (out_body_length),
    .out_payload_value  (out_payload_value),
    .out_tempo_found    (out_tempo_found),
    .out_tempo_micros   (out_tempo_micros),
    .out_track_finished (out_track_finished),
    .mismatches         (mismatch_total),
    .pending            (records_pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Idle rate for the next stretch: none, light or heavy.
  function automatic int pick_idle_pct();
    case ($urandom_range(2, 0))
      0:       return 0;
      1:       return 4;
      default: return 25;
    endcase
  endfunction

  function automatic logic has_two_data(input logic [7:0] st);
    return !(st[7:4] == mtep_pkg::HI_PROG || st[7:4] == mtep_pkg::HI_CHAN_PRESS);
  endfunction

  // Append one byte to the track body.
  task automatic add_body_byte(input logic [7:0] b);
    body_bytes.insert(body_bytes.size(), b);
  endtask

  // Append one byte to the input stream.
  task automatic add_feed_byte(input logic [7:0] b);
    feed_bytes.insert(feed_bytes.size(), b);
  endtask

  // Delta time of a given byte count with random content.
  task automatic push_delta(input int nbytes);
    for (int k = 1; k < nbytes; k++) add_body_byte(8'h80 | 8'($urandom_range(127, 0)));
    add_body_byte(8'($urandom_range(127, 0)));
  endtask

  // A lead byte with bit 7 set is an explicit status; otherwise it is the
  // first data byte under running status.
  task automatic push_chan(input logic [7:0] lead, input logic [7:0] d1, input logic [7:0] d2);
    add_body_byte(lead);
    if (lead[7]) begin
      gen_running = lead;
      add_body_byte(d1);
      if (has_two_data(lead)) add_body_byte(d2);
    end else if (has_two_data(gen_running)) begin
      add_body_byte(d1);
    end
  endtask

  // Meta or sysex event with a random payload. The long length form carries
  // leading groups that are shifted out past 32 bits.
  task automatic push_body_event(input logic [7:0] lead, input logic [7:0] mtype,
                                 input logic [13:0] len, input logic long_form);
    add_body_byte(lead);
    if (lead == mtep_pkg::ST_META) add_body_byte(mtype);
    if (long_form) begin
      add_body_byte(8'h80 | 8'($urandom_range(127, 0)));
      add_body_byte(8'h80 | (8'($urandom_range(127, 0)) & 8'h70));
      add_body_byte(8'h80);
      add_body_byte(8'h80);
      add_body_byte({1'b1, len[13:7]});
      add_body_byte({1'b0, len[6:0]});
    end else if (len > 14'd127) begin
      add_body_byte({1'b1, len[13:7]});
      add_body_byte({1'b0, len[6:0]});
    end else begin
      add_body_byte({1'b0, len[6:0]});
    end
    repeat (len) add_body_byte(8'($urandom_range(255, 0)));
  endtask

  // One delta and one event of random shape; never an end of track.
  task automatic add_random_event();
    int          pick;
    int          dlen;
    logic [7:0]  st;
    logic [7:0]  mtype;
    logic [13:0] len;
    pick = $urandom_range(9, 0);
    if (pick < 7) dlen = 1;
    else if (pick < 9) dlen = $urandom_range(3, 2);
    else dlen = $urandom_range(6, 4);
    push_delta(dlen);
    pick = $urandom_range(99, 0);
    if (pick < 35) begin
      st = 8'h80 | 8'($urandom_range(127, 0));
      if (st == mtep_pkg::ST_META || st == mtep_pkg::ST_SYSEX || st == mtep_pkg::ST_SYSEX_ESC)
        st = 8'h90 | (st & 8'h0F);
      push_chan(st, 8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)));
    end else if (pick < 55) begin
      push_chan(8'($urandom_range(127, 0)), 8'($urandom_range(255, 0)), 8'h00);
    end else if (pick < 78) begin
      mtype = 8'($urandom_range(255, 0));
      if (mtype == mtep_pkg::META_END || $urandom_range(2, 0) == 0) mtype = mtep_pkg::META_TEMPO;
      if (mtype == mtep_pkg::META_TEMPO && $urandom_range(4, 0) != 0) len = 14'd3;
      else if ($urandom_range(9, 0) == 0) len = 14'($urandom_range(140, 128));
      else len = 14'($urandom_range(6, 0));
      push_body_event(mtep_pkg::ST_META, mtype, len, $urandom_range(9, 0) == 0);
    end else begin
      push_body_event($urandom_range(1, 0) ? mtep_pkg::ST_SYSEX : mtep_pkg::ST_SYSEX_ESC,
                      8'h00, 14'($urandom_range(8, 0)), $urandom_range(9, 0) == 0);
    end
  endtask

  // Result side: random stall bursts, none in the last part of the run.
  initial begin : result_sink
    int stall_left;
    int stall_pct;
    int cyc;
    out_ready  = 1'b0;
    stall_left = 0;
    stall_pct  = 0;
    cyc        = 0;
    forever begin
      @(negedge clk);
      if (cyc % 128 == 0) stall_pct = pick_idle_pct();
      cyc++;
      if (tail_calm) begin
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if ($urandom_range(99, 0) < stall_pct) begin
        out_ready  <= 1'b0;
        stall_left = $urandom_range(16, 0);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Ends the run when no transaction happens on either channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    int          idx;
    int          gap_pct;
    int          start;
    logic        end_by_meta;
    logic [31:0] chunk_len;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_byte     = 8'h00;
    tail_calm   = 1'b0;
    gap_pct     = 0;
    gen_running = 8'h00;

    // Directed opening: running status before any status byte, the largest
    // four-byte delta, a one-data-byte status with a high data byte and its
    // running reuse, a tempo, empty and one-byte sysex, and a system byte
    // taken as channel status behind a six-byte delta.
    add_body_byte(8'h00);
    push_chan(8'h40, 8'h7F, 8'h00);
    add_body_byte(8'hFF);
    add_body_byte(8'hFF);
    add_body_byte(8'hFF);
    add_body_byte(8'h7F);
    push_chan(8'hC5, 8'h80, 8'h00);
    add_body_byte(8'h00);
    push_chan(8'h12, 8'h00, 8'h00);
    add_body_byte(8'h00);
    push_body_event(mtep_pkg::ST_META, mtep_pkg::META_TEMPO, 14'd3, 1'b0);
    add_body_byte(8'h00);
    push_body_event(mtep_pkg::ST_SYSEX, 8'h00, 14'd0, 1'b0);
    add_body_byte(8'h00);
    push_body_event(mtep_pkg::ST_SYSEX_ESC, 8'h00, 14'd1, 1'b0);
    push_delta(6);
    push_chan(8'hF8, 8'h00, 8'hFF);

    while (body_bytes.size() < BODY_TARGET) add_random_event();

    // The track ends either on the end meta event under a large length, or
    // on the length reached at, or overrun by, the last event.
    end_by_meta = 1'($urandom_range(1, 0));
    if (end_by_meta) begin
      push_delta(1);
      push_body_event(mtep_pkg::ST_META, mtep_pkg::META_END, 14'($urandom_range(2, 0)), 1'b0);
      chunk_len = $urandom | 32'h8000_0000;
    end else begin
      start = body_bytes.size();
      add_random_event();
      chunk_len = body_bytes.size() - $urandom_range(body_bytes.size() - start - 1, 0);
    end

    repeat (4) add_feed_byte(8'($urandom_range(255, 0)));
    for (idx = 3; idx >= 0; idx--) add_feed_byte(chunk_len[8*idx +: 8]);
    foreach (body_bytes[k]) add_feed_byte(body_bytes[k]);
    // Trailing bytes after the end of the track must be taken and ignored.
    repeat (6) add_feed_byte(8'($urandom_range(255, 0)));

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // One input transaction per byte, with random gap bursts before some.
    for (idx = 0; idx < feed_bytes.size(); idx++) begin
      if (idx % 64 == 0) gap_pct = pick_idle_pct();
      if (idx >= feed_bytes.size() - TAIL_ITEMS) tail_calm <= 1'b1;
      if (!tail_calm && $urandom_range(99, 0) < gap_pct) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(17, 1)) @(negedge clk);
      end
      in_valid <= 1'b1;
      in_byte  <= feed_bytes[idx];
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      @(negedge clk);
    end
    in_valid <= 1'b0;

    while (records_pending != 0) @(negedge clk);
    repeat (DRAIN_LIMIT) @(negedge clk);

    if (mismatch_total == 0 && records_pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
